[rtl/assert_macros.svh]
// Assertion helpers; every use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every clock edge out of reset.
`define SIDT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define SIDT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SIDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sidt_pkg.sv]
`default_nettype none
package sidt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRIES_W   = 5;
  localparam int CFG_ADDR_W  = 3;

  localparam logic REQ_DISPATCH    = 1'b1;
  localparam logic CFG_IDX_WILDCARD = 1'b0;

  typedef enum logic [1:0] {
    STAT_REGISTERED = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_MATCH      = 2'd2,
    STAT_NO_MATCH   = 2'd3
  } status_t;

  typedef enum logic {
    OP_REGISTER = 1'b0,
    OP_DISPATCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_DSP_CHK,
    ST_DSP_END
  } state_t;

  typedef struct packed {
    logic              req_type;
    logic signed [31:0] order_key;
    logic [7:0]        event_code;
    logic [7:0]        target_id;
  } in_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [7:0]           matched_id;
    logic                 is_last;
    logic [ENTRIES_W-1:0] entries_used;
  } out_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         event_code;
    logic [7:0]         target;
  } entry_t;

  typedef struct packed {
    op_t    op;
    entry_t entry;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/sorted_irq_dispatch_table.sv]
// Register beat: ST_INS_CMP shifts each entry with a larger key up one slot, then
// ST_INS_PUT stores the new entry and emits; a full table answers STAT_FULL from idle.
// Dispatch beat: ST_DSP_CHK checks each stored entry, ST_DSP_END emits the last result.
// Throughput: walks one entry per cycle unless stalled; 2-beat queue in front.
// Reset (synchronous, rst_n low) empties the table count, queue and output and sets
// wildcard_event to 0; the table memory itself is not cleared.
`default_nettype none
module sorted_irq_dispatch_table (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  sidt_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output sidt_pkg::out_t                     out_data,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sidt_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  logic [7:0]     wildcard_r;
  logic           cfg_wr;
  logic           cmd_valid, cmd_pop;
  sidt_pkg::cmd_t cmd;

  assign pready = 1'b1;
  // register index is the word address bit
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == sidt_pkg::CFG_IDX_WILDCARD);
  assign prdata = (paddr[2] == sidt_pkg::CFG_IDX_WILDCARD) ? {24'd0, wildcard_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wildcard_r <= 8'd0;
    end else if (cfg_wr) begin
      wildcard_r <= pwdata[7:0];
    end
  end

  sidt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  sidt_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .wildcard_event (wildcard_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data)
  );

endmodule
`default_nettype wire

[rtl/sidt_front.sv]
`default_nettype none
module sidt_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  sidt_pkg::in_t     in_data,
  output logic              cmd_valid,
  output sidt_pkg::cmd_t    cmd,
  input  wire logic         cmd_pop
);

  sidt_pkg::cmd_t q_r [2];
  sidt_pkg::cmd_t cls;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;

  always_comb begin
    cls.op           = (in_data.req_type == sidt_pkg::REQ_DISPATCH) ?
                       sidt_pkg::OP_DISPATCH : sidt_pkg::OP_REGISTER;
    cls.entry.key        = in_data.order_key;
    cls.entry.event_code = in_data.event_code;
    cls.entry.target     = in_data.target_id;
  end

  assign in_stall  = (fill_r == 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

[rtl/sidt_back.sv]
`default_nettype none
`include "assert_macros.svh"
module sidt_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cmd_valid,
  input  sidt_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  wire logic [7:0]   wildcard_event,
  output logic              out_valid,
  input  wire logic         out_stall,
  output sidt_pkg::out_t    out_data
);

  localparam int IDX_W = sidt_pkg::IDX_W;
  localparam int CNT_W = sidt_pkg::CNT_W;

  sidt_pkg::entry_t mem [sidt_pkg::TABLE_DEPTH];
  sidt_pkg::entry_t rd_data_r;
  sidt_pkg::entry_t wr_data;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             we;

  sidt_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, count_m1;
  sidt_pkg::cmd_t   cmd_r, cmd_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [7:0]       pend_id_r, pend_id_nxt;

  logic             out_valid_r;
  sidt_pkg::out_t   out_r;
  logic             out_free, emit, hit;
  sidt_pkg::status_t emit_status;
  logic [7:0]       emit_id;
  logic             emit_last;
  logic             in_insert, put_go;

  assign out_free  = !out_valid_r || !out_stall;
  assign count_m1  = count_r - CNT_W'(1);
  assign hit       = (rd_data_r.event_code == cmd_r.entry.event_code) ||
                     (rd_data_r.event_code == wildcard_event);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign in_insert = (state_r == sidt_pkg::ST_INS_CMP) || (state_r == sidt_pkg::ST_INS_PUT);
  assign put_go    = (state_r == sidt_pkg::ST_INS_PUT) && out_free;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    pend_valid_nxt = pend_valid_r;
    pend_id_nxt    = pend_id_r;
    cmd_pop        = 1'b0;
    rd_addr        = idx_r;
    we             = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data_r;
    emit           = 1'b0;
    emit_status    = sidt_pkg::STAT_REGISTERED;
    emit_id        = 8'd0;
    emit_last      = 1'b1;
    case (state_r)
      sidt_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == sidt_pkg::OP_REGISTER) begin
            if (count_r == CNT_W'(sidt_pkg::TABLE_DEPTH)) begin
              if (out_free) begin
                cmd_pop     = 1'b1;
                emit        = 1'b1;
                emit_status = sidt_pkg::STAT_FULL;
              end
            end else begin
              cmd_pop = 1'b1;
              cmd_nxt = cmd;
              idx_nxt = IDX_W'(count_r);
              if (count_r == '0) begin
                state_nxt = sidt_pkg::ST_INS_PUT;
              end else begin
                rd_addr   = IDX_W'(count_m1);
                state_nxt = sidt_pkg::ST_INS_CMP;
              end
            end
          end else begin
            if (count_r == '0) begin
              if (out_free) begin
                cmd_pop     = 1'b1;
                emit        = 1'b1;
                emit_status = sidt_pkg::STAT_NO_MATCH;
              end
            end else begin
              cmd_pop        = 1'b1;
              cmd_nxt        = cmd;
              idx_nxt        = '0;
              rd_addr        = '0;
              pend_valid_nxt = 1'b0;
              state_nxt      = sidt_pkg::ST_DSP_CHK;
            end
          end
        end
      end
      sidt_pkg::ST_INS_CMP: begin
        // rd_data_r holds entry idx-1; shift it up while its key is larger
        if ($signed(rd_data_r.key) > $signed(cmd_r.entry.key)) begin
          we      = 1'b1;
          wr_data = rd_data_r;
          idx_nxt = idx_r - IDX_W'(1);
          if (idx_r == IDX_W'(1)) begin
            state_nxt = sidt_pkg::ST_INS_PUT;
          end else begin
            rd_addr = idx_r - IDX_W'(2);
          end
        end else begin
          state_nxt = sidt_pkg::ST_INS_PUT;
        end
      end
      sidt_pkg::ST_INS_PUT: begin
        if (out_free) begin
          we          = 1'b1;
          wr_data     = cmd_r.entry;
          count_nxt   = count_r + CNT_W'(1);
          emit        = 1'b1;
          emit_status = sidt_pkg::STAT_REGISTERED;
          state_nxt   = sidt_pkg::ST_IDLE;
        end
      end
      sidt_pkg::ST_DSP_CHK: begin
        // one match is held back so the final one can carry is_last
        if (!(hit && pend_valid_r && !out_free)) begin
          if (hit) begin
            if (pend_valid_r) begin
              emit        = 1'b1;
              emit_status = sidt_pkg::STAT_MATCH;
              emit_id     = pend_id_r;
              emit_last   = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_id_nxt    = rd_data_r.target;
          end
          if (idx_r == IDX_W'(count_m1)) begin
            state_nxt = sidt_pkg::ST_DSP_END;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
            rd_addr = idx_r + IDX_W'(1);
          end
        end
      end
      sidt_pkg::ST_DSP_END: begin
        if (out_free) begin
          emit           = 1'b1;
          emit_status    = pend_valid_r ? sidt_pkg::STAT_MATCH : sidt_pkg::STAT_NO_MATCH;
          emit_id        = pend_valid_r ? pend_id_r : 8'd0;
          pend_valid_nxt = 1'b0;
          state_nxt      = sidt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sidt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sidt_pkg::ST_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    cmd_r     <= cmd_nxt;
    pend_id_r <= pend_id_nxt;
    if (emit) begin
      out_r.status       <= emit_status;
      out_r.matched_id   <= emit_id;
      out_r.is_last      <= emit_last;
      out_r.entries_used <= sidt_pkg::ENTRIES_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  `SIDT_ASSERT(a_count_bound, count_r <= CNT_W'(sidt_pkg::TABLE_DEPTH), "entry count overflow")
  `SIDT_ASSERT_IMPL(a_we_insert_only, we, in_insert, "table written outside insert")
  `SIDT_ASSERT_IMPL(a_emit_room, emit, out_free, "result emitted into a busy output register")
  `SIDT_ASSERT_NEXT(a_put_counts, put_go, count_r == $past(count_r) + CNT_W'(1), "count not bumped")

endmodule
`default_nettype wire
